// ===== rtl/hex_bitmap_body_parser_defines.svh =====
// Assertion macros used by the hex bitmap body parser RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef HEX_BITMAP_BODY_PARSER_DEFINES_SVH
`define HEX_BITMAP_BODY_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define HBBP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hbbp same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define HBBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hbbp next-cycle check failed");

`endif

// ===== rtl/hbbp_pkg.sv =====
// Package for the hex bitmap body parser: item types, codes, constants and helpers.
// No dependencies.
package hbbp_pkg;

	localparam int MAX_ROW_BYTES = 4096;
	localparam int ROW_BYTES_W = 13;
	localparam int ROW_COUNT_W = 16;
	localparam int COL_OUT_W = 12;
	localparam int COL_CNT_W = 17;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_BYTES = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT = 4'd1;

	// Result kinds
	localparam logic [1:0] KIND_PIXEL = 2'd0;
	localparam logic [1:0] KIND_END = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Characters of interest
	localparam logic [7:0] CH_BRACE = 8'h7D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_X = 8'h78;

	localparam logic [3:0] NIBBLE_REV [16] = '{
		4'd0, 4'd8, 4'd4, 4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
		4'd1, 4'd9, 4'd5, 4'd13, 4'd3, 4'd11, 4'd7, 4'd15
	};

	typedef enum logic [2:0] {
		PH_SEEK,
		PH_WANT_X,
		PH_DIGIT1,
		PH_DIGIT2,
		PH_DIGIT2_BAD,
		PH_HALT
	} phase_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       source_error;
	} in_t;

	typedef struct packed {
		logic [1:0]           result_kind;
		logic [7:0]           pixel_byte;
		logic [COL_OUT_W-1:0] column;
		logic [15:0]          row;
	} out_t;

	// Settings as the parser sees them
	typedef struct packed {
		logic [ROW_BYTES_W-1:0] eff_row_bytes;
		logic [ROW_COUNT_W-1:0] row_count;
	} cfg_t;

	// Hex digit decode: bit 4 set marks a character that is not a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
		return r;
	endfunction

endpackage

// ===== rtl/hbbp_cfg_regs.sv =====
// Configuration registers of the hex bitmap body parser, with row width clamping.
// Depends on hbbp_pkg.
module hbbp_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [hbbp_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [hbbp_pkg::CFG_DATA_W-1:0]    cfg_data,
	output hbbp_pkg::cfg_t                     cfg
);
	import hbbp_pkg::*;

	logic [ROW_BYTES_W-1:0] row_bytes_q;
	logic [ROW_COUNT_W-1:0] row_count_q;

	assign cfg_ready = 1'b1;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= ROW_BYTES_W'(1);
			row_count_q <= ROW_COUNT_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ROW_BYTES: row_bytes_q <= cfg_data[ROW_BYTES_W-1:0];
				CFG_ROW_COUNT: row_count_q <= cfg_data[ROW_COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Zero acts as one, oversize acts as the maximum
	always_comb begin
		if (row_bytes_q == '0) cfg.eff_row_bytes = ROW_BYTES_W'(1);
		else if (row_bytes_q > ROW_BYTES_W'(MAX_ROW_BYTES))
			cfg.eff_row_bytes = ROW_BYTES_W'(MAX_ROW_BYTES);
		else cfg.eff_row_bytes = row_bytes_q;
		cfg.row_count = row_count_q;
	end

endmodule

// ===== rtl/hbbp_core.sv =====
// Parser state machine: phase, first digit, column and row counters, result decode.
// Depends on hbbp_pkg and hex_bitmap_body_parser_defines.svh.
`include "hex_bitmap_body_parser_defines.svh"

module hbbp_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  hbbp_pkg::in_t  item,
	input  hbbp_pkg::cfg_t cfg,
	output logic           has_result,
	output hbbp_pkg::out_t result
);
	import hbbp_pkg::*;

	phase_t                 phase_q, phase_d;
	logic [3:0]             first_q, first_d;
	logic [COL_CNT_W-1:0]   col_q, col_d;
	logic [15:0]            row_q, row_d;

	logic [4:0]             hv;
	logic                   hex_bad;
	logic                   row_full;
	logic [15:0]            row_inc;
	logic                   row_over;
	logic                   fail;

	// Shared decode
	assign hv = hex_digit(item.char_in);
	assign hex_bad = hv[4];
	assign row_full = (col_q == COL_CNT_W'(cfg.eff_row_bytes));
	assign row_inc = row_q + 16'd1;
	assign row_over = (row_inc == cfg.row_count);

	// Conditions that stop the parser with an error (source error or bad format)
	always_comb begin
		fail = 1'b0;
		if (phase_q != PH_HALT) begin
			if (item.source_error) fail = 1'b1;
			else begin
				case (phase_q)
					PH_WANT_X:     fail = (item.char_in != CH_X);
					PH_DIGIT2:     fail = hex_bad || (row_full && row_over);
					PH_DIGIT2_BAD: fail = 1'b1;
					default:       fail = 1'b0;
				endcase
			end
		end
	end

	// Next state
	always_comb begin
		phase_d = phase_q;
		first_d = first_q;
		col_d = col_q;
		row_d = row_q;
		if (fail) phase_d = PH_HALT;
		else begin
			case (phase_q)
				PH_SEEK: begin
					if (item.char_in == CH_BRACE) phase_d = PH_HALT;
					else if (item.char_in == CH_ZERO) phase_d = PH_WANT_X;
				end
				PH_WANT_X: phase_d = PH_DIGIT1;
				PH_DIGIT1: begin
					if (hex_bad) phase_d = PH_DIGIT2_BAD;
					else begin
						first_d = hv[3:0];
						phase_d = PH_DIGIT2;
					end
				end
				PH_DIGIT2: begin
					col_d = (row_full ? '0 : col_q) + COL_CNT_W'(1);
					row_d = row_full ? row_inc : row_q;
					phase_d = PH_SEEK;
				end
				default: ;
			endcase
		end
	end

	// Result for this item
	always_comb begin
		has_result = 1'b0;
		result = '0;
		if (fail) begin
			has_result = 1'b1;
			result.result_kind = KIND_ERROR;
		end else begin
			case (phase_q)
				PH_SEEK: begin
					if (item.char_in == CH_BRACE) begin
						has_result = 1'b1;
						result.result_kind = KIND_END;
					end
				end
				PH_DIGIT2: begin
					has_result = 1'b1;
					result.result_kind = KIND_PIXEL;
					result.pixel_byte = {NIBBLE_REV[hv[3:0]], NIBBLE_REV[first_q]};
					result.column = row_full ? '0 : col_q[COL_OUT_W-1:0];
					result.row = row_full ? row_inc : row_q;
				end
				default: ;
			endcase
		end
	end

	// State registers advance once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			first_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			first_q <= first_d;
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	`HBBP_ASSERT_NEXT(a_halt_sticky, clk, arst_n, phase_q == PH_HALT, phase_q == PH_HALT)
	`HBBP_ASSERT_IMPLIES(a_halt_silent, clk, arst_n, phase_q == PH_HALT, !has_result)
	`HBBP_ASSERT_NEXT(a_stop_halts, clk, arst_n, step && has_result && result.result_kind != KIND_PIXEL, phase_q == PH_HALT)
	`HBBP_ASSERT_NEXT(a_pixel_seeks, clk, arst_n, step && has_result && result.result_kind == KIND_PIXEL, phase_q == PH_SEEK && col_q != '0)

endmodule

// ===== rtl/hex_bitmap_body_parser.sv =====
// A result reaches out_data through the input stage register and then the result register.
// Throughput: one character item per cycle while the result register is free or draining; the per-item phase
// update is combinational logic between the input stage register and the result register.
// Items that cause no result (skipped characters, the 0 and x of a literal, first hex digits) leave no output.
// Reset (arst_n low): parser seeks a literal, row 0 column 0, row_bytes = row_count = 1.
// Depends on hbbp_pkg, hbbp_cfg_regs and hbbp_core.
module hex_bitmap_body_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  hbbp_pkg::in_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output hbbp_pkg::out_t                    out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hbbp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [hbbp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import hbbp_pkg::*;

	cfg_t cfg;
	in_t  item_s1;
	logic valid_s1;
	logic adv_s1;
	logic has_result;
	out_t result;
	out_t res_s2;
	logic valid_s2;

	hbbp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage 1 item moves on when the result register is free or draining
	assign adv_s1 = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	hbbp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv_s1),
		.item       (item_s1),
		.cfg        (cfg),
		.has_result (has_result),
		.result     (result)
	);

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (in_ready) valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_s1 <= in_data;
	end

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (adv_s1) valid_s2 <= has_result;
		else if (out_ready) valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_result) res_s2 <= result;
	end

	assign out_valid = valid_s2;
	assign out_data = res_s2;

endmodule
